>>> hdl/keyframe_lerp_affine_matrix_defines.svh
// Assertion macros shared by the keyframe transform block.
`ifndef KEYFRAME_LERP_AFFINE_MATRIX_DEFINES_SVH
`define KEYFRAME_LERP_AFFINE_MATRIX_DEFINES_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define KLAM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define KLAM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/klam_pkg.sv
`default_nettype none
package klam_pkg;
	localparam int MAX_KEYS  = 64;
	localparam int KEY_W     = $clog2(MAX_KEYS);
	localparam int N_W       = KEY_W + 1;
	localparam int NUM_COMP  = 11;
	localparam int MEM_DEPTH = MAX_KEYS * NUM_COMP;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int FRAC_BITS = 16;
	localparam int KC_W      = 7;
	localparam int W         = 32;
	localparam int MUL_W     = W + 1;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int QP_W      = 2 * W - FRAC_BITS;
	localparam int ROT_W     = QP_W + 4;
	localparam int CNT_W     = $clog2((FRAC_BITS > 10) ? FRAC_BITS : 10);
	localparam int IN_W      = 80;
	localparam int OUT_W     = 136;

	localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(FRAC_BITS - 1);
	localparam logic [CNT_W-1:0] LAST_COMP = CNT_W'(9);
	localparam logic [CNT_W-1:0] LAST_PROD = CNT_W'(8);
	localparam logic [CNT_W-1:0] LAST_ROW  = CNT_W'(3);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_TLAST, S_TLAST_W, S_SRCH, S_SRCH_W, S_T0, S_T0_W, S_DIV,
		S_LA, S_LB, S_LM, S_LS, S_QM, S_QS, S_MM, S_MS, S_OUT
	} state_t;

	typedef enum logic [2:0] {RD_TLAST, RD_TK1, RD_TK, RD_A, RD_B} rd_sel_t;

	typedef struct packed {
		logic             start;
		logic             chk_hold;
		logic             k_inc;
		logic             cap_t1;
		logic             cap_t0;
		logic             div_step;
		logic             cap_a;
		logic             lerp_mul;
		logic             lerp_sum;
		logic             q_mul;
		logic             q_store;
		logic             m_mul;
		logic             m_store;
		logic             out_load;
		rd_sel_t          rd;
		logic [CNT_W-1:0] idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic hold;
		logic more;
		logic ratio_zero;
		logic out_free;
	} ctl_sts_t;
endpackage
`default_nettype wire

>>> hdl/klam_apb.sv
`default_nettype none
module klam_apb (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        psel,
	input  wire                        penable,
	input  wire                        pwrite,
	input  wire [2:0]                  paddr,
	input  wire [31:0]                 pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [klam_pkg::KC_W-1:0]  key_count
);
	import klam_pkg::*;

	logic [KC_W-1:0] key_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= KC_W'(1);
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			key_count_q <= pwdata[KC_W-1:0];
		end
	end

	assign pready    = 1'b1;
	assign prdata    = paddr[2] ? 32'd0 : {{(32-KC_W){1'b0}}, key_count_q};
	assign key_count = key_count_q;
endmodule
`default_nettype wire

>>> hdl/klam_ctrl.sv
`default_nettype none
`include "keyframe_lerp_affine_matrix_defines.svh"
module klam_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  s_tuser,
	output logic                 s_tready,
	input  klam_pkg::ctl_sts_t   sts,
	output klam_pkg::ctl_cmd_t   cmd
);
	import klam_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tuser == CMD_EVAL) state_d = S_TLAST;
			end
			S_TLAST: state_d = S_TLAST_W;
			S_TLAST_W: begin
				cnt_d = '0;
				state_d = sts.hold ? S_LA : S_SRCH;
			end
			S_SRCH: state_d = S_SRCH_W;
			S_SRCH_W: state_d = sts.more ? S_SRCH : S_T0;
			S_T0: state_d = S_T0_W;
			S_T0_W: begin
				cnt_d = '0;
				state_d = sts.ratio_zero ? S_LA : S_DIV;
			end
			S_DIV: begin
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					state_d = S_LA;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_LA: state_d = S_LB;
			S_LB: state_d = S_LM;
			S_LM: state_d = S_LS;
			S_LS: begin
				if (cnt_q == LAST_COMP) begin
					cnt_d = '0;
					state_d = S_QM;
				end else begin
					cnt_d = cnt_q + 1'b1;
					state_d = S_LA;
				end
			end
			S_QM: state_d = S_QS;
			S_QS: begin
				if (cnt_q == LAST_PROD) begin
					cnt_d = '0;
					state_d = S_MM;
				end else begin
					cnt_d = cnt_q + 1'b1;
					state_d = S_QM;
				end
			end
			S_MM: state_d = S_MS;
			S_MS: begin
				if (cnt_q == LAST_PROD) begin
					cnt_d = '0;
					state_d = S_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
					state_d = S_MM;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					if (cnt_q == LAST_ROW) begin
						cnt_d = '0;
						state_d = S_IDLE;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
				cnt_d = '0;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd = RD_TLAST;
		cmd.idx = cnt_q;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.start = s_tvalid;
			end
			S_TLAST: cmd.rd = RD_TLAST;
			S_TLAST_W: cmd.chk_hold = 1'b1;
			S_SRCH: cmd.rd = RD_TK1;
			S_SRCH_W: begin
				cmd.k_inc  = sts.more;
				cmd.cap_t1 = !sts.more;
			end
			S_T0: cmd.rd = RD_TK;
			S_T0_W: cmd.cap_t0 = 1'b1;
			S_DIV: cmd.div_step = 1'b1;
			S_LA: cmd.rd = RD_A;
			S_LB: begin
				cmd.rd = RD_B;
				cmd.cap_a = 1'b1;
			end
			S_LM: cmd.lerp_mul = 1'b1;
			S_LS: cmd.lerp_sum = 1'b1;
			S_QM: cmd.q_mul = 1'b1;
			S_QS: cmd.q_store = 1'b1;
			S_MM: cmd.m_mul = 1'b1;
			S_MS: cmd.m_store = 1'b1;
			S_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	`KLAM_ASSERT_IMP(a_out_free, cmd.out_load, sts.out_free, "row loaded over a pending result")
	`KLAM_ASSERT_NXT(a_eval_go, s_tvalid && s_tready && s_tuser == CMD_EVAL, state_q == S_TLAST, "evaluate request not started")
	`KLAM_ASSERT_IMP(a_comp_rng, state_q == S_LS, cnt_q <= LAST_COMP, "component counter out of range")
	`KLAM_ASSERT_NXT(a_run_end, state_q == S_OUT && sts.out_free && cnt_q == LAST_ROW, state_q == S_IDLE, "run did not end after row 3")
endmodule
`default_nettype wire

>>> hdl/klam_dp.sv
`default_nettype none
module klam_dp (
	input  wire                               clk,
	input  wire                               arst_n,
	input  klam_pkg::ctl_cmd_t                cmd,
	output klam_pkg::ctl_sts_t                sts,
	input  wire                               s_tuser,
	input  wire [klam_pkg::IN_W-1:0]          s_tdata,
	input  wire [klam_pkg::KC_W-1:0]          key_count,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [klam_pkg::OUT_W-1:0]        m_tdata,
	output logic [1:0]                        m_tuser,
	output logic                              m_tlast
);
	import klam_pkg::*;

	function automatic logic signed [W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(64'sh7FFF_FFFF);
		lo = -hi - PROD_W'(1);
		if (v > hi) return {1'b0, {(W-1){1'b1}}};
		if (v < lo) return {1'b1, {(W-1){1'b0}}};
		return v[W-1:0];
	endfunction

	function automatic logic [1:0] row_of(input logic [CNT_W-1:0] i);
		case (i)
			CNT_W'(0), CNT_W'(1), CNT_W'(2): return 2'd0;
			CNT_W'(3), CNT_W'(4), CNT_W'(5): return 2'd1;
			default: return 2'd2;
		endcase
	endfunction

	logic [KEY_W-1:0]  in_key;
	logic [3:0]        in_comp;
	logic [W-1:0]      in_value;
	logic [W-2:0]      in_time;
	logic [KEY_W-1:0]  in_hint;

	assign in_key   = s_tdata[KEY_W-1:0];
	assign in_comp  = s_tdata[9:6];
	assign in_value = s_tdata[41:10];
	assign in_time  = s_tdata[72:42];
	assign in_hint  = s_tdata[78:73];

	logic [W-1:0]      mem [MEM_DEPTH];
	logic [W-1:0]      rd_q;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              wr_en;

	logic [W-2:0]              t_q;
	logic [N_W-1:0]            n_q;
	logic [KEY_W-1:0]          lastk_q, k_q, kbase_q;
	logic                      hold_q;
	logic signed [W-1:0]       t1_q, a_q;
	logic [W:0]                den_q;
	logic [W+1:0]              rem_q;
	logic [FRAC_BITS-1:0]      ratio_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [W-1:0]       v_q [10];
	logic signed [QP_W-1:0]    qp_q [9];
	logic signed [W-1:0]       m_q [9];

	logic                      out_valid_q;
	logic [1:0]                out_row_q;
	logic [W-1:0]              out_c0_q, out_c1_q, out_c2_q, out_c3_q;
	logic [KEY_W-1:0]          out_key_q;

	logic [N_W-1:0]   n_c, kmax;
	logic [KEY_W-1:0] k_init;
	logic [KEY_W-1:0] rd_key;
	logic [3:0]       rd_comp;
	logic signed [W:0] t_s, rd_s, num_s, den_s;
	logic             hold_c, more_c;
	logic [W+1:0]     rem2;
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [ROT_W-1:0] rot_sel, one_r;
	logic signed [ROT_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;

	always_comb begin
		if (key_count == '0) n_c = N_W'(1);
		else if (int'(key_count) > MAX_KEYS) n_c = N_W'(MAX_KEYS);
		else n_c = N_W'(key_count);
		kmax = (n_c >= N_W'(2)) ? n_c - N_W'(2) : '0;
		k_init = ({1'b0, in_hint} < kmax) ? in_hint : kmax[KEY_W-1:0];
	end

	assign wr_en   = cmd.start && s_tuser == CMD_LOAD && in_comp < 4'(NUM_COMP);
	assign wr_addr = ADDR_W'(in_key) * ADDR_W'(NUM_COMP) + ADDR_W'(in_comp);

	always_comb begin
		rd_key  = lastk_q;
		rd_comp = 4'd0;
		case (cmd.rd)
			RD_TLAST: rd_key = lastk_q;
			RD_TK1:   rd_key = k_q + 1'b1;
			RD_TK:    rd_key = k_q;
			RD_A: begin
				rd_key  = kbase_q;
				rd_comp = 4'(cmd.idx) + 4'd1;
			end
			RD_B: begin
				rd_key  = kbase_q + KEY_W'(!hold_q);
				rd_comp = 4'(cmd.idx) + 4'd1;
			end
			default: rd_key = lastk_q;
		endcase
	end
	assign rd_addr = ADDR_W'(rd_key) * ADDR_W'(NUM_COMP) + ADDR_W'(rd_comp);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= in_value;
		rd_q <= mem[rd_addr];
	end

	assign t_s   = $signed({2'b00, t_q});
	assign rd_s  = $signed({rd_q[W-1], rd_q});
	assign num_s = t_s - rd_s;
	assign den_s = $signed({t1_q[W-1], t1_q}) - rd_s;
	assign hold_c = (n_q < N_W'(2)) || (t_s >= rd_s);
	assign more_c = ({1'b0, k_q} < n_q - N_W'(2)) && (t_s >= rd_s);
	assign rem2   = {rem_q[W:0], 1'b0};

	assign one_r = ROT_W'(1) <<< FRAC_BITS;
	assign xx = ROT_W'(qp_q[0]);
	assign yy = ROT_W'(qp_q[1]);
	assign zz = ROT_W'(qp_q[2]);
	assign xy = ROT_W'(qp_q[3]);
	assign xz = ROT_W'(qp_q[4]);
	assign yz = ROT_W'(qp_q[5]);
	assign xw = ROT_W'(qp_q[6]);
	assign yw = ROT_W'(qp_q[7]);
	assign zw = ROT_W'(qp_q[8]);

	always_comb begin
		case (cmd.idx)
			CNT_W'(0): rot_sel = one_r - ((yy + zz) <<< 1);
			CNT_W'(1): rot_sel = (xy + zw) <<< 1;
			CNT_W'(2): rot_sel = (xz - yw) <<< 1;
			CNT_W'(3): rot_sel = (xy - zw) <<< 1;
			CNT_W'(4): rot_sel = one_r - ((xx + zz) <<< 1);
			CNT_W'(5): rot_sel = (yz + xw) <<< 1;
			CNT_W'(6): rot_sel = (xz + yw) <<< 1;
			CNT_W'(7): rot_sel = (yz - xw) <<< 1;
			default:   rot_sel = one_r - ((xx + yy) <<< 1);
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.lerp_mul) begin
			mul_a = rd_s - $signed({a_q[W-1], a_q});
			mul_b = $signed({{(MUL_W-FRAC_BITS){1'b0}}, ratio_q});
		end else if (cmd.q_mul) begin
			case (cmd.idx)
				CNT_W'(0): begin mul_a = MUL_W'(v_q[3]); mul_b = MUL_W'(v_q[3]); end
				CNT_W'(1): begin mul_a = MUL_W'(v_q[4]); mul_b = MUL_W'(v_q[4]); end
				CNT_W'(2): begin mul_a = MUL_W'(v_q[5]); mul_b = MUL_W'(v_q[5]); end
				CNT_W'(3): begin mul_a = MUL_W'(v_q[3]); mul_b = MUL_W'(v_q[4]); end
				CNT_W'(4): begin mul_a = MUL_W'(v_q[3]); mul_b = MUL_W'(v_q[5]); end
				CNT_W'(5): begin mul_a = MUL_W'(v_q[4]); mul_b = MUL_W'(v_q[5]); end
				CNT_W'(6): begin mul_a = MUL_W'(v_q[3]); mul_b = MUL_W'(v_q[6]); end
				CNT_W'(7): begin mul_a = MUL_W'(v_q[4]); mul_b = MUL_W'(v_q[6]); end
				default:   begin mul_a = MUL_W'(v_q[5]); mul_b = MUL_W'(v_q[6]); end
			endcase
		end else if (cmd.m_mul) begin
			mul_a = MUL_W'(sat32(PROD_W'(rot_sel)));
			mul_b = MUL_W'(v_q[row_of(cmd.idx)]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && s_tuser == CMD_EVAL) begin
			t_q     <= in_time;
			n_q     <= n_c;
			lastk_q <= KEY_W'(n_c - N_W'(1));
			k_q     <= k_init;
		end
		if (cmd.chk_hold) begin
			hold_q <= hold_c;
			if (hold_c) begin
				kbase_q <= lastk_q;
				ratio_q <= '0;
			end
		end
		if (cmd.k_inc) k_q <= k_q + 1'b1;
		if (cmd.cap_t1) t1_q <= rd_q;
		if (cmd.cap_t0) begin
			kbase_q <= k_q;
			ratio_q <= '0;
			rem_q   <= {1'b0, num_s};
			den_q   <= den_s;
		end
		if (cmd.div_step) begin
			if (rem2 >= {1'b0, den_q}) begin
				rem_q   <= rem2 - {1'b0, den_q};
				ratio_q <= {ratio_q[FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_q   <= rem2;
				ratio_q <= {ratio_q[FRAC_BITS-2:0], 1'b0};
			end
		end
		if (cmd.cap_a) a_q <= rd_q;
		if (cmd.lerp_mul || cmd.q_mul || cmd.m_mul) prod_q <= mul_a * mul_b;
		if (cmd.lerp_sum) v_q[cmd.idx] <= a_q + prod_q[FRAC_BITS+W-1:FRAC_BITS];
		if (cmd.q_store) qp_q[cmd.idx] <= prod_q[FRAC_BITS+QP_W-1:FRAC_BITS];
		if (cmd.m_store) m_q[cmd.idx] <= sat32(prod_q >>> FRAC_BITS);
		if (cmd.out_load) begin
			out_row_q <= cmd.idx[1:0];
			out_key_q <= k_q;
			case (cmd.idx[1:0])
				2'd0: begin
					out_c0_q <= m_q[0]; out_c1_q <= m_q[1]; out_c2_q <= m_q[2];
					out_c3_q <= '0;
				end
				2'd1: begin
					out_c0_q <= m_q[3]; out_c1_q <= m_q[4]; out_c2_q <= m_q[5];
					out_c3_q <= '0;
				end
				2'd2: begin
					out_c0_q <= m_q[6]; out_c1_q <= m_q[7]; out_c2_q <= m_q[8];
					out_c3_q <= '0;
				end
				default: begin
					out_c0_q <= v_q[7]; out_c1_q <= v_q[8]; out_c2_q <= v_q[9];
					out_c3_q <= W'(1) << FRAC_BITS;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.hold       = hold_c;
	assign sts.more       = more_c;
	assign sts.ratio_zero = (num_s <= 0) || (den_s <= 0);
	assign sts.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_row_q;
	assign m_tlast  = out_row_q == 2'd3;
	assign m_tdata  = {{(OUT_W-4*W-KEY_W){1'b0}}, out_key_q,
		out_c3_q, out_c2_q, out_c1_q, out_c0_q};
endmodule
`default_nettype wire

>>> hdl/keyframe_lerp_affine_matrix.sv
// A load request writes its value into the table as it is accepted. An evaluate request that
// holds the last key skips the key search and the ratio divider; one that interpolates walks
// the keys forward from the hint, then divides for the ratio unless it is zero. Rows 1-3 follow
// one per cycle when the sink is ready, and the next request is taken once row 3 sits in the
// output register. The block uses a bit-serial ratio divider and one shared multiplier.
// Reset clears the controller and the output valid flag and sets key_count to 1, not the table.
`default_nettype none
module keyframe_lerp_affine_matrix (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [2:0]                    paddr,
	input  wire [31:0]                   pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	// key_index[5:0], component[9:6], value[41:10], play_time[72:42], key_hint[78:73]
	input  wire [klam_pkg::IN_W-1:0]     s_tdata,
	// cmd[0]
	input  wire                          s_tuser,
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// col0[31:0], col1[63:32], col2[95:64], col3[127:96], found_key[133:128]
	output logic [klam_pkg::OUT_W-1:0]   m_tdata,
	// row[1:0]
	output logic [1:0]                   m_tuser,
	output logic                         m_tlast
);
	import klam_pkg::*;

	logic [KC_W-1:0] key_count;
	ctl_cmd_t        cmd;
	ctl_sts_t        sts;

	klam_apb u_apb (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.key_count(key_count)
	);

	klam_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tuser(s_tuser),
		.s_tready(s_tready), .sts(sts), .cmd(cmd)
	);

	klam_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .s_tuser(s_tuser),
		.s_tdata(s_tdata), .key_count(key_count), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
	);
endmodule
`default_nettype wire
